// ----- src/dpa_pkg.sv -----
// Shared types and constants for the dining philosophers ring arbiter.
`timescale 1ns / 1ps

package dpa_pkg;

   // Per-seat state codes.
   localparam logic [1:0] ST_THINK  = 2'd0;
   localparam logic [1:0] ST_HUNGRY = 2'd1;
   localparam logic [1:0] ST_EAT    = 2'd2;

   // Input item function codes.
   localparam logic FUNC_REQUEST = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // Seat count register.
   localparam int         SEAT_COUNT_W     = 5;
   localparam logic [4:0] SEAT_COUNT_RESET = 5'd5;

   // Field widths fixed by the item format.
   localparam int SEAT_W = 4;

   // Read address select codes.
   localparam logic [1:0] RD_TARGET = 2'd0;
   localparam logic [1:0] RD_LEFT   = 2'd1;
   localparam logic [1:0] RD_RIGHT  = 2'd2;

   // Input item.
   typedef struct packed {
      logic              func;
      logic [SEAT_W-1:0] seat;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [SEAT_W-1:0] grant_seat;
      logic              last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic [1:0] rd_sel;
      logic       ok_init;
      logic       ok_and;
      logic       check;
      logic       tgt_right;
      logic       emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_range;
      logic req_func;
      logic grant;
      logic have_grant;
      logic out_free;
      logic emit_final;
   } sts_type;

endpackage

// ----- src/dpa_datapath.sv -----
// Datapath of the ring arbiter: seat state memory, neighbor test and grant buffer.
`timescale 1ns / 1ps

module dpa_datapath #(
   parameter int MAX_SEATS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [dpa_pkg::SEAT_COUNT_W-1:0]   csr_data,
   input  dpa_pkg::req_type                   req_payload,
   input  dpa_pkg::cmd_type                   cmd,
   output dpa_pkg::sts_type                   sts,
   output logic                               rsp_valid,
   output dpa_pkg::rsp_type                   rsp_payload,
   input  logic                               rsp_stall
);

   localparam int IDX_W = $clog2(MAX_SEATS);
   localparam int CNT_W = $clog2(MAX_SEATS + 1);

   // Left neighbor in a ring of n seats.
   function automatic logic [IDX_W-1:0] left_of(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] n);
      logic [31:0] v;
      begin
         if (i == '0) begin
            v = 32'(n) - 32'd1;
         end else begin
            v = 32'(i) - 32'd1;
         end
         return v[IDX_W-1:0];
      end
   endfunction

   // Right neighbor in a ring of n seats.
   function automatic logic [IDX_W-1:0] right_of(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] n);
      logic [31:0] v;
      begin
         v = 32'(i) + 32'd1;
         if (v == 32'(n)) begin
            v = 32'd0;
         end
         return v[IDX_W-1:0];
      end
   endfunction

   logic [dpa_pkg::SEAT_COUNT_W-1:0] seat_count_ff;
   logic [CNT_W-1:0]                 used_n;
   logic [31:0]                      seat_ext;
   logic [IDX_W-1:0]                 seat_idx;
   logic                             in_range;

   logic [1:0]       state_mem_ff [MAX_SEATS];
   logic [MAX_SEATS-1:0] written_ff;
   logic [1:0]       rd_data_ff;
   logic             rd_valid_ff;
   logic [1:0]       rd_state;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [1:0]       wr_data;

   logic [IDX_W-1:0] target_ff, target_in;
   logic [IDX_W-1:0] seat_ff, seat_in;
   logic             ok_ff, ok_in;
   logic [IDX_W-1:0] g0_ff, g0_in;
   logic [IDX_W-1:0] g1_ff, g1_in;
   logic [1:0]       gcnt_ff, gcnt_in;
   logic             emit_idx_ff, emit_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   dpa_pkg::rsp_type rsp_ff, rsp_in;

   logic             grant;
   logic             out_free;
   logic             emit_final;
   logic [31:0]      emit_seat_ext;

   // Seat count register: user must write it only while block is idle; unchecked.
   always_ff @(posedge clock) begin
      if (reset) begin
         seat_count_ff <= dpa_pkg::SEAT_COUNT_RESET;
      end else if (csr_valid) begin
         seat_count_ff <= csr_data;
      end
   end

   // Effective ring size, clamped to one and to the storage depth.
   always_comb begin
      if (seat_count_ff == '0) begin
         used_n = CNT_W'(1);
      end else if (32'(seat_count_ff) > MAX_SEATS) begin
         used_n = CNT_W'(MAX_SEATS);
      end else begin
         used_n = CNT_W'(seat_count_ff);
      end
   end

   // Incoming seat index and range check.
   assign seat_ext = 32'(req_payload.seat);
   assign seat_idx = seat_ext[IDX_W-1:0];
   assign in_range = seat_ext < 32'(used_n);

   // Read address select.
   always_comb begin
      case (cmd.rd_sel)
         dpa_pkg::RD_LEFT:  rd_addr = left_of(target_ff, used_n);
         dpa_pkg::RD_RIGHT: rd_addr = right_of(target_ff, used_n);
         default:           rd_addr = target_ff;
      endcase
   end

   // Write port: the item's own seat on accept, the target on a grant.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = target_ff;
      wr_data = dpa_pkg::ST_EAT;
      if (cmd.accept) begin
         wr_en   = 1'b1;
         wr_addr = seat_idx;
         wr_data = (req_payload.func == dpa_pkg::FUNC_RELEASE) ?
                   dpa_pkg::ST_THINK : dpa_pkg::ST_HUNGRY;
      end else if (cmd.check && grant) begin
         wr_en = 1'b1;
      end
   end

   // Seat state memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= state_mem_ff[rd_addr];
   end

   // Written flags: an entry never written reads as thinking.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff  <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= written_ff[rd_addr];
      end
   end

   assign rd_state = rd_valid_ff ? rd_data_ff : dpa_pkg::ST_THINK;

   // The target wins when it is hungry and neither neighbor is eating.
   assign grant      = ok_ff && (rd_state != dpa_pkg::ST_EAT);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_final = ({1'b0, emit_idx_ff} + 2'd1) == gcnt_ff;
   assign emit_seat_ext = emit_idx_ff ? 32'(g1_ff) : 32'(g0_ff);

   // Next values of the working registers and the output register.
   always_comb begin
      target_in    = target_ff;
      seat_in      = seat_ff;
      ok_in        = ok_ff;
      g0_in        = g0_ff;
      g1_in        = g1_ff;
      gcnt_in      = gcnt_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.accept) begin
         seat_in     = seat_idx;
         target_in   = (req_payload.func == dpa_pkg::FUNC_RELEASE) ?
                       left_of(seat_idx, used_n) : seat_idx;
         gcnt_in     = 2'd0;
         emit_idx_in = 1'b0;
      end

      if (cmd.ok_init) begin
         ok_in = (rd_state == dpa_pkg::ST_HUNGRY);
      end else if (cmd.ok_and) begin
         ok_in = ok_ff && (rd_state != dpa_pkg::ST_EAT);
      end

      if (cmd.check && grant) begin
         if (gcnt_ff == 2'd0) begin
            g0_in = target_ff;
         end else begin
            g1_in = target_ff;
         end
         gcnt_in = gcnt_ff + 2'd1;
      end

      if (cmd.tgt_right) begin
         target_in = right_of(seat_ff, used_n);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.grant_seat = emit_seat_ext[dpa_pkg::SEAT_W-1:0];
         rsp_in.last       = emit_final;
         emit_idx_in       = emit_idx_ff + 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gcnt_ff      <= 2'd0;
         emit_idx_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gcnt_ff      <= gcnt_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      target_ff <= target_in;
      seat_ff   <= seat_in;
      ok_ff     <= ok_in;
      g0_ff     <= g0_in;
      g1_ff     <= g1_in;
      rsp_ff    <= rsp_in;
   end

   // Status to the controller.
   always_comb begin
      sts.in_range   = in_range;
      sts.req_func   = req_payload.func;
      sts.grant      = grant;
      sts.have_grant = (gcnt_ff != 2'd0);
      sts.out_free   = out_free;
      sts.emit_final = emit_final;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // An item never buffers more than two grants.
   a_gcnt_max: assert property (@(posedge clock) disable iff (reset)
      gcnt_ff != 2'd3)
      else $error("grant buffer overflow");

   // A grant goes out only when one is buffered and the output can take it.
   a_emit_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (gcnt_ff != 2'd0) && out_free)
      else $error("emit without a buffered grant or a free output");

   // The grant decision follows the last neighbor read.
   a_check_order: assert property (@(posedge clock) disable iff (reset)
      cmd.check |-> $past(cmd.ok_and))
      else $error("grant check out of sequence");

endmodule

// ----- src/dpa_controller.sv -----
// Controller state machine of the ring arbiter: sequences the seat tests and grant output.
`timescale 1ns / 1ps

module dpa_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dpa_pkg::sts_type sts,
   output dpa_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD_T = 3'd1;
   localparam logic [2:0] S_RD_L = 3'd2;
   localparam logic [2:0] S_RD_R = 3'd3;
   localparam logic [2:0] S_CHK  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   localparam logic [1:0] PH_REQ   = 2'd0;
   localparam logic [1:0] PH_LEFT  = 2'd1;
   localparam logic [1:0] PH_RIGHT = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.rd_sel = dpa_pkg::RD_TARGET;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && sts.in_range) begin
               cmd.accept = 1'b1;
               phase_in   = (sts.req_func == dpa_pkg::FUNC_RELEASE) ? PH_LEFT : PH_REQ;
               state_in   = S_RD_T;
            end
         end
         S_RD_T: begin
            cmd.rd_sel = dpa_pkg::RD_TARGET;
            state_in   = S_RD_L;
         end
         S_RD_L: begin
            cmd.rd_sel  = dpa_pkg::RD_LEFT;
            cmd.ok_init = 1'b1;
            state_in    = S_RD_R;
         end
         S_RD_R: begin
            cmd.rd_sel = dpa_pkg::RD_RIGHT;
            cmd.ok_and = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            cmd.check = 1'b1;
            case (phase_ff)
               PH_LEFT: begin
                  cmd.tgt_right = 1'b1;
                  phase_in      = PH_RIGHT;
                  state_in      = S_RD_T;
               end
               PH_RIGHT: begin
                  state_in = (sts.grant || sts.have_grant) ? S_EMIT : S_IDLE;
               end
               default: begin
                  state_in = sts.grant ? S_EMIT : S_IDLE;
               end
            endcase
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_final) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_REQ;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // The grant check always comes straight after the right neighbor read.
   a_chk_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> ($past(state_ff) == S_RD_R))
      else $error("grant check entered out of sequence");

endmodule

// ----- src/dining_philosophers_arbiter.sv -----
// Top level of the dining philosophers ring arbiter.
`timescale 1ns / 1ps

// Ring arbiter for seats that share one resource with each neighbor. A request item
// makes its seat hungry and grants it if neither neighbor is eating; a release item
// makes its seat thinking and re-tests the left, then the right neighbor. Each grant
// is one result item, and the last grant of an input item has last set. Items whose
// seat is at or above the effective seat count give no result. Items are handled one
// at a time: a new item is taken only once the last one's seat tests and grants
// are done, and a stall on the result side holds the block. The seat state memory
// has one registered read port, so each seat test reads the seat and its two
// neighbors in turn. The seat count register takes writes at any time but must
// only be written while no item is in flight.
module dining_philosophers_arbiter #(
   parameter int MAX_SEATS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dpa_pkg::SEAT_COUNT_W-1:0] csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dpa_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dpa_pkg::rsp_type                 rsp_payload
);

   dpa_pkg::cmd_type cmd;
   dpa_pkg::sts_type sts;

   // The seat count register is always ready.
   assign csr_ready = 1'b1;

   // Sequencer.
   dpa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // State memory and grant path.
   dpa_datapath #(
      .MAX_SEATS (MAX_SEATS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule

// ----- tb/sv/dining_philosophers_arbiter_tb.sv -----
// Self-checking testbench for the dining philosophers ring arbiter.
`timescale 1ns / 1ps

module dining_philosophers_arbiter_tb;

   localparam int MAX_SEATS  = 16;
   // Drain margin for the block to finish an item; leave room for stalls.
   localparam int DRAIN      = 30;
   localparam int HOLD       = 64;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_LEN  = 140;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             csr_valid   = 1'b0;
   logic                             csr_ready;
   logic [dpa_pkg::SEAT_COUNT_W-1:0] csr_data    = '0;
   logic                             req_valid   = 1'b0;
   logic                             req_stall;
   dpa_pkg::req_type                 req_payload = '0;
   logic                             rsp_valid;
   logic                             rsp_stall   = 1'b0;
   dpa_pkg::rsp_type                 rsp_payload;

   // Shadow copy of the ring state and the seat count register.
   logic [1:0]                       seat_mode [MAX_SEATS];
   logic [dpa_pkg::SEAT_COUNT_W-1:0] seat_cnt;
   dpa_pkg::rsp_type                 pending_grants [$];

   int fail_count  = 0;
   bit calm        = 1'b0;
   bit hold_on     = 1'b0;
   bit rsp_taken   = 1'b0;
   int stall_left  = 0;
   int idle_cycles = 0;

   dining_philosophers_arbiter #(.MAX_SEATS(MAX_SEATS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Effective ring size: a count of zero acts as one, anything above the maximum clamps.
   function automatic int used_seats();
      int n;
      n = int'(seat_cnt);
      if (n < 1) n = 1;
      if (n > MAX_SEATS) n = MAX_SEATS;
      return n;
   endfunction

   // Grant seat i if it is hungry and neither ring neighbor is eating.
   function automatic bit try_eat(input int i, input int n);
      if (seat_mode[i] == dpa_pkg::ST_HUNGRY &&
          seat_mode[(i + n - 1) % n] != dpa_pkg::ST_EAT &&
          seat_mode[(i + 1) % n] != dpa_pkg::ST_EAT) begin
         seat_mode[i] = dpa_pkg::ST_EAT;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Update the shadow ring for one accepted item and queue the grants it causes.
   function automatic void predict_grants(input dpa_pkg::req_type it);
      int               n;
      int               s;
      int               cands [$];
      dpa_pkg::rsp_type g [$];
      dpa_pkg::rsp_type r;
      n = used_seats();
      s = int'(it.seat);
      if (s >= n) return;
      if (it.func == dpa_pkg::FUNC_REQUEST) begin
         seat_mode[s] = dpa_pkg::ST_HUNGRY;
         cands.push_back(s);
      end else begin
         seat_mode[s] = dpa_pkg::ST_THINK;
         cands.push_back((s + n - 1) % n);
         cands.push_back((s + 1) % n);
      end
      foreach (cands[k]) begin
         if (try_eat(cands[k], n)) begin
            r.grant_seat = dpa_pkg::SEAT_W'(cands[k]);
            r.last       = 1'b0;
            g.push_back(r);
         end
      end
      if (g.size() > 0) g[g.size() - 1].last = 1'b1;
      foreach (g[k]) pending_grants.push_back(g[k]);
   endfunction

   // Offer one item after a random gap and hold it until the block takes it.
   task automatic send_item(input logic f, input int s);
      int               gap;
      dpa_pkg::req_type it;
      it.func = f;
      it.seat = dpa_pkg::SEAT_W'(s);
      gap = calm ? 0 : int'($urandom_range(0, 3));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_grants(it);
      @(negedge clock);
   endtask

   // Stop offering, let every expected grant arrive, then let the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic write_seat_count(input int v);
      csr_valid <= 1'b1;
      csr_data  <= dpa_pkg::SEAT_COUNT_W'(v);
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      seat_cnt = dpa_pkg::SEAT_COUNT_W'(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Returns an eating seat inside the ring, or -1 when nobody eats.
   function automatic int pick_eating(input int n);
      int start;
      int idx;
      start = int'($urandom_range(0, n - 1));
      for (int k = 0; k < n; k++) begin
         idx = (start + k) % n;
         if (seat_mode[idx] == dpa_pkg::ST_EAT) return idx;
      end
      return -1;
   endfunction

   // Five seats from reset: blocking, hand-over on release and out-of-range seats.
   task automatic test_default_ring();
      send_item(dpa_pkg::FUNC_REQUEST, 0);
      send_item(dpa_pkg::FUNC_REQUEST, 1);
      send_item(dpa_pkg::FUNC_REQUEST, 4);
      send_item(dpa_pkg::FUNC_REQUEST, 2);
      send_item(dpa_pkg::FUNC_RELEASE, 0);
      // A seat that asks again while eating is granted again.
      send_item(dpa_pkg::FUNC_REQUEST, 2);
      // Releasing a seat that is not eating still re-tests both neighbors.
      send_item(dpa_pkg::FUNC_RELEASE, 3);
      send_item(dpa_pkg::FUNC_REQUEST, 7);
      send_item(dpa_pkg::FUNC_RELEASE, 15);
      send_item(dpa_pkg::FUNC_RELEASE, 2);
      send_item(dpa_pkg::FUNC_RELEASE, 4);
      wait_idle();
   endtask

   // One seat is its own neighbor; a count of zero behaves the same.
   task automatic test_single_seat();
      write_seat_count(1);
      send_item(dpa_pkg::FUNC_REQUEST, 0);
      send_item(dpa_pkg::FUNC_REQUEST, 0);
      send_item(dpa_pkg::FUNC_RELEASE, 0);
      send_item(dpa_pkg::FUNC_REQUEST, 1);
      wait_idle();
      write_seat_count(0);
      send_item(dpa_pkg::FUNC_REQUEST, 0);
      send_item(dpa_pkg::FUNC_RELEASE, 0);
      wait_idle();
   endtask

   // With two seats both neighbors coincide, so a release grants at most once.
   task automatic test_two_seats();
      write_seat_count(2);
      send_item(dpa_pkg::FUNC_REQUEST, 0);
      send_item(dpa_pkg::FUNC_REQUEST, 1);
      send_item(dpa_pkg::FUNC_RELEASE, 0);
      send_item(dpa_pkg::FUNC_RELEASE, 1);
      wait_idle();
   endtask

   // Full ring, including a count above the maximum, with wrap at seat 15.
   task automatic test_full_ring();
      write_seat_count(31);
      send_item(dpa_pkg::FUNC_REQUEST, 15);
      send_item(dpa_pkg::FUNC_REQUEST, 0);
      send_item(dpa_pkg::FUNC_RELEASE, 15);
      wait_idle();
      write_seat_count(MAX_SEATS);
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering.
   task automatic test_result_backpressure();
      hold_on = 1'b1;
      for (int s = 0; s < MAX_SEATS; s += 2) send_item(dpa_pkg::FUNC_REQUEST, s);
      for (int s = 1; s < MAX_SEATS; s += 2) send_item(dpa_pkg::FUNC_REQUEST, s);
      for (int s = 0; s < MAX_SEATS; s += 2) send_item(dpa_pkg::FUNC_RELEASE, s);
      wait_idle();
   endtask

   // Random traffic across several ring sizes, mostly in range, with hand-overs.
   task automatic test_random_traffic();
      int counts [10] = '{3, 16, 7, 2, 1, 5, 31, 0, 12, 16};
      int n;
      int s;
      int roll;
      logic f;
      foreach (counts[p]) begin
         wait_idle();
         write_seat_count(counts[p]);
         calm = (p == 3 || p == 8);
         for (int k = 0; k < PHASE_LEN; k++) begin
            n    = used_seats();
            roll = int'($urandom_range(0, 99));
            s    = -1;
            f    = 1'($urandom_range(0, 1));
            if (roll < 35) begin
               s = pick_eating(n);
               f = dpa_pkg::FUNC_RELEASE;
            end
            if (s < 0) begin
               f = 1'($urandom_range(0, 1));
               s = (roll >= 88) ? int'($urandom_range(0, 15)) :
                                  int'($urandom_range(0, n - 1));
            end
            send_item(f, s);
         end
         calm = 1'b0;
      end
      wait_idle();
   endtask

   // Result side stall: a random hold-off per result, or one long hold on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_on) begin
            rsp_stall <= 1'b1;
            for (int i = 0; i < HOLD; i++) @(negedge clock);
            rsp_stall  <= 1'b0;
            stall_left = 0;
            hold_on    = 1'b0;
         end else begin
            if (rsp_taken) begin
               stall_left = calm ? 0 : int'($urandom_range(0, 3));
               rsp_taken  = 1'b0;
            end
            if (stall_left > 0) begin
               rsp_stall <= 1'b1;
               stall_left--;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Compare each accepted grant with the oldest expectation.
   always @(posedge clock) begin
      dpa_pkg::rsp_type want;
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_taken = 1'b1;
         if (pending_grants.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected grant: seat %0d last %0b",
                        rsp_payload.grant_seat, rsp_payload.last);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_payload.grant_seat !== want.grant_seat || rsp_payload.last !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("grant mismatch: expected seat %0d last %0b, got seat %0d last %0b",
                           want.grant_seat, want.last, rsp_payload.grant_seat, rsp_payload.last);
            end
         end
      end
   end

   // Watchdog: end the run when no handshake happens for too long.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_valid && csr_ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      foreach (seat_mode[i]) seat_mode[i] = dpa_pkg::ST_THINK;
      seat_cnt = dpa_pkg::SEAT_COUNT_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_ring();
      test_single_seat();
      test_two_seats();
      test_full_ring();
      test_result_backpressure();
      test_random_traffic();
      if (pending_grants.size() != 0) fail_count++;
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/dpa_pkg.sv
src/dpa_datapath.sv
src/dpa_controller.sv
src/dining_philosophers_arbiter.sv
tb/sv/dining_philosophers_arbiter_tb.sv
